// File: src/sspq_pkg.sv
package sspq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int VAL_W = 32;
	localparam int PRI_W = 8;
	localparam int TOL_W = 16;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef logic [1:0] op_t;
	localparam op_t OP_PUSH   = 2'd0;
	localparam op_t OP_POP    = 2'd1;
	localparam op_t OP_FIND   = 2'd2;
	localparam op_t OP_UNUSED = 2'd3;

	typedef logic [1:0] stat_code_t;
	localparam stat_code_t STAT_OK    = 2'd0;
	localparam stat_code_t STAT_EMPTY = 2'd1;
	localparam stat_code_t STAT_FULL  = 2'd2;
	localparam stat_code_t STAT_MISS  = 2'd3;

	localparam logic signed [PRI_W-1:0] DEFAULT_PRIORITY = 8'sd7;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_clr;
		logic scan_step;
		logic scan_miss;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic hit;
		logic at_end;
	} dp_stat_t;

endpackage

// File: src/sspq_datapath.sv
module sspq_datapath (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  sspq_pkg::cmd_t                            cmd,
	output sspq_pkg::dp_stat_t                        dp_stat,
	input  logic                                      cfg_we,
	input  logic [sspq_pkg::TOL_W-1:0]                cfg_wdata,
	input  logic [1:0]                                operation,
	input  logic signed [sspq_pkg::VAL_W-1:0]         value,
	input  logic signed [sspq_pkg::PRI_W-1:0]         priority_req,
	output logic [1:0]                                status,
	output logic signed [sspq_pkg::VAL_W-1:0]         item_value,
	output logic signed [sspq_pkg::PRI_W-1:0]         item_priority,
	output logic [sspq_pkg::CNT_W-1:0]                entry_count
);

	logic signed [sspq_pkg::VAL_W-1:0] val_q [sspq_pkg::DEPTH];
	logic signed [sspq_pkg::PRI_W-1:0] pri_q [sspq_pkg::DEPTH];
	sspq_pkg::cnt_t                    count_q;
	logic [sspq_pkg::TOL_W-1:0]        tol_q;

	sspq_pkg::op_t                     op_q;
	logic signed [sspq_pkg::VAL_W-1:0] in_val_q;
	logic signed [sspq_pkg::PRI_W-1:0] in_pri_q;
	sspq_pkg::cnt_t                    idx_q;

	sspq_pkg::stat_code_t              res_status_q;
	logic signed [sspq_pkg::VAL_W-1:0] res_val_q;
	logic signed [sspq_pkg::PRI_W-1:0] res_pri_q;

	logic [sspq_pkg::DEPTH-1:0]        le;
	logic                              full;
	logic                              empty;
	logic signed [sspq_pkg::VAL_W-1:0] scan_val;
	logic signed [sspq_pkg::PRI_W-1:0] scan_pri;
	logic signed [sspq_pkg::VAL_W:0]   diff;
	logic [sspq_pkg::VAL_W:0]          abs_diff;
	logic                              at_end;
	logic                              hit;

	// Held entries are sorted, so the entries at or below the new priority form a prefix.
	always_comb begin
		for (int i = 0; i < sspq_pkg::DEPTH; i++) begin
			le[i] = (sspq_pkg::cnt_t'(i) < count_q) && (pri_q[i] <= in_pri_q);
		end
	end

	assign full  = (count_q == sspq_pkg::cnt_t'(sspq_pkg::DEPTH));
	assign empty = (count_q == '0);

	assign scan_val = val_q[idx_q[sspq_pkg::IDX_W-1:0]];
	assign scan_pri = pri_q[idx_q[sspq_pkg::IDX_W-1:0]];
	assign diff     = {scan_val[sspq_pkg::VAL_W-1], scan_val}
	                - {in_val_q[sspq_pkg::VAL_W-1], in_val_q};
	assign abs_diff = diff[sspq_pkg::VAL_W] ? (~diff + 1'b1) : diff;
	assign at_end   = (idx_q >= count_q);
	assign hit      = !at_end && (scan_pri == in_pri_q)
	                && (abs_diff < {{(sspq_pkg::VAL_W + 1 - sspq_pkg::TOL_W){1'b0}}, tol_q});

	assign dp_stat.op     = op_q;
	assign dp_stat.hit    = hit;
	assign dp_stat.at_end = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tol_q   <= sspq_pkg::TOL_RESET;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (cmd.exec && op_q == sspq_pkg::OP_PUSH && !full) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.exec && op_q == sspq_pkg::OP_POP && !empty) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage: push opens a slot by shifting the tail up, pop shifts everything down.
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == sspq_pkg::OP_PUSH && !full) begin
			for (int i = 0; i < sspq_pkg::DEPTH; i++) begin
				if (!le[i]) begin
					if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
						val_q[i] <= in_val_q;
						pri_q[i] <= in_pri_q;
					end else begin
						val_q[i] <= val_q[(i == 0) ? 0 : i - 1];
						pri_q[i] <= pri_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end else if (cmd.exec && op_q == sspq_pkg::OP_POP && !empty) begin
			for (int i = 0; i < sspq_pkg::DEPTH - 1; i++) begin
				val_q[i] <= val_q[i + 1];
				pri_q[i] <= pri_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= sspq_pkg::OP_PUSH;
			idx_q <= '0;
		end else begin
			if (cmd.capture) begin
				op_q <= operation;
			end
			if (cmd.scan_clr) begin
				idx_q <= '0;
			end else if (cmd.scan_step && !hit) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_val_q <= value;
			in_pri_q <= priority_req;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= sspq_pkg::STAT_OK;
			res_val_q    <= '0;
			res_pri_q    <= sspq_pkg::DEFAULT_PRIORITY;
			case (op_q)
				sspq_pkg::OP_PUSH: begin
					if (full) begin
						res_status_q <= sspq_pkg::STAT_FULL;
					end
				end
				sspq_pkg::OP_POP: begin
					if (empty) begin
						res_status_q <= sspq_pkg::STAT_EMPTY;
					end else begin
						res_val_q <= val_q[0];
						res_pri_q <= pri_q[0];
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.scan_miss) begin
			res_status_q <= sspq_pkg::STAT_MISS;
			res_val_q    <= '0;
			res_pri_q    <= sspq_pkg::DEFAULT_PRIORITY;
		end else if (cmd.scan_step && hit) begin
			res_status_q <= sspq_pkg::STAT_OK;
			res_val_q    <= scan_val;
			res_pri_q    <= scan_pri;
		end
	end

	assign status        = res_status_q;
	assign item_value    = res_val_q;
	assign item_priority = res_pri_q;
	assign entry_count   = count_q;

endmodule

// File: src/sspq_ctrl.sv
module sspq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  sspq_pkg::dp_stat_t   dp_stat,
	output sspq_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_SCAN   = 4'b0100,
		S_RESP   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.scan_clr = 1'b1;
				if (dp_stat.op == sspq_pkg::OP_FIND) begin
					state_d = S_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_RESP;
				end
			end
			S_SCAN: begin
				// Entries are visited head first, so the first hit is the one returned.
				if (dp_stat.at_end) begin
					cmd.scan_miss = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
					if (dp_stat.hit) begin
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/stable_sorted_priority_queue_core.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     operation, value, priority_req
// out       output     out_valid / out_ready   status, item_value, item_priority, entry_count
// cfg       input      cfg_we                  cfg_wdata (match tolerance)
//
// One transaction at a time. Push, pop and the unused code go from acceptance in IDLE through
// DECODE, where the operation executes, to RESP, where the result is valid; the next transaction
// is accepted in IDLE after the result is taken. Find goes from DECODE to SCAN instead, where the
// single compare unit checks one entry per cycle from the head until a hit or the end of the queue.
// A result holds until taken and no new input is accepted before then, so an output stall
// lengthens the transaction. Reset empties the queue and sets the tolerance to 7.
module stable_sorted_priority_queue_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          operation,
	input  logic signed [sspq_pkg::VAL_W-1:0]   value,
	input  logic signed [sspq_pkg::PRI_W-1:0]   priority_req,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic signed [sspq_pkg::VAL_W-1:0]   item_value,
	output logic signed [sspq_pkg::PRI_W-1:0]   item_priority,
	output logic [sspq_pkg::CNT_W-1:0]          entry_count,
	input  logic                                cfg_we,
	input  logic [sspq_pkg::TOL_W-1:0]          cfg_wdata
);

	sspq_pkg::cmd_t     cmd;
	sspq_pkg::dp_stat_t dp_stat;

	sspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	sspq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.dp_stat       (dp_stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (operation),
		.value         (value),
		.priority_req  (priority_req),
		.status        (status),
		.item_value    (item_value),
		.item_priority (item_priority),
		.entry_count   (entry_count)
	);

endmodule

// File: tb/stable_sorted_priority_queue_core_test.sv
`timescale 1ns / 100ps

module stable_sorted_priority_queue_core_test;

	typedef logic signed [sspq_pkg::VAL_W-1:0] val_t;
	typedef logic signed [sspq_pkg::PRI_W-1:0] pri_t;
	typedef logic [sspq_pkg::TOL_W-1:0]        tol_t;

	typedef struct {
		sspq_pkg::op_t                      op;
		logic signed [sspq_pkg::VAL_W-1:0]  val;
		logic signed [sspq_pkg::PRI_W-1:0]  pri;
	} queue_cmd_t;

	typedef struct {
		sspq_pkg::stat_code_t               st;
		logic signed [sspq_pkg::VAL_W-1:0]  val;
		logic signed [sspq_pkg::PRI_W-1:0]  pri;
		sspq_pkg::cnt_t                     cnt;
	} queue_reply_t;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [1:0]                          operation = sspq_pkg::OP_PUSH;
	logic signed [sspq_pkg::VAL_W-1:0]   value = '0;
	logic signed [sspq_pkg::PRI_W-1:0]   priority_req = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [1:0]                          status;
	logic signed [sspq_pkg::VAL_W-1:0]   item_value;
	logic signed [sspq_pkg::PRI_W-1:0]   item_priority;
	logic [sspq_pkg::CNT_W-1:0]          entry_count;
	logic                                cfg_we = 1'b0;
	logic [sspq_pkg::TOL_W-1:0]          cfg_wdata = '0;

	stable_sorted_priority_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value(value),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.item_value(item_value),
		.item_priority(item_priority),
		.entry_count(entry_count),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	queue_cmd_t   cmds_to_send[$];
	queue_reply_t replies_due[$];
	queue_cmd_t   recent_pushes[$];
	int           cmds_made = 0;
	int           errors = 0;
	int           op_seen[4] = '{0, 0, 0, 0};
	int           stat_seen[4] = '{0, 0, 0, 0};

	// Mirror of the sorted list: head at index 0.
	logic signed [sspq_pkg::VAL_W-1:0] held_val[sspq_pkg::DEPTH];
	logic signed [sspq_pkg::PRI_W-1:0] held_pri[sspq_pkg::DEPTH];
	int                                held_n = 0;
	logic [sspq_pkg::TOL_W-1:0]        tolerance = sspq_pkg::TOL_RESET;

	function automatic queue_reply_t queue_step(input queue_cmd_t c);
		queue_reply_t r;
		int pos;
		longint diff;
		bit hit;
		r.st = sspq_pkg::STAT_OK;
		r.val = '0;
		r.pri = sspq_pkg::DEFAULT_PRIORITY;
		hit = 1'b0;
		case (c.op)
		sspq_pkg::OP_PUSH: begin
			if (held_n >= sspq_pkg::DEPTH) begin
				r.st = sspq_pkg::STAT_FULL;
			end else begin
				// Equal priorities keep arrival order, so insert behind them.
				pos = 0;
				while (pos < held_n && held_pri[pos] <= c.pri)
					pos++;
				for (int i = held_n; i > pos; i--) begin
					held_val[i] = held_val[i-1];
					held_pri[i] = held_pri[i-1];
				end
				held_val[pos] = c.val;
				held_pri[pos] = c.pri;
				held_n++;
			end
		end
		sspq_pkg::OP_POP: begin
			if (held_n == 0) begin
				r.st = sspq_pkg::STAT_EMPTY;
			end else begin
				r.val = held_val[0];
				r.pri = held_pri[0];
				for (int i = 1; i < held_n; i++) begin
					held_val[i-1] = held_val[i];
					held_pri[i-1] = held_pri[i];
				end
				held_n--;
			end
		end
		sspq_pkg::OP_FIND: begin
			for (int i = 0; i < held_n && !hit; i++) begin
				diff = longint'(held_val[i]) - longint'(c.val);
				if (diff < 0)
					diff = -diff;
				if (held_pri[i] == c.pri && diff < longint'(tolerance)) begin
					hit = 1'b1;
					r.val = held_val[i];
					r.pri = held_pri[i];
				end
			end
			if (!hit)
				r.st = sspq_pkg::STAT_MISS;
		end
		default: ;
		endcase
		r.cnt = sspq_pkg::cnt_t'(held_n);
		return r;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	queue_cmd_t   on_wire;
	queue_reply_t fresh_reply;
	int           burst_left = 1;
	int           gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				fresh_reply = queue_step(on_wire);
				replies_due.push_back(fresh_reply);
				op_seen[on_wire.op]++;
				stat_seen[fresh_reply.st]++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmds_to_send.size() > 0) begin
					on_wire = cmds_to_send.pop_front();
					in_valid <= 1'b1;
					operation <= on_wire.op;
					value <= on_wire.val;
					priority_req <= on_wire.pri;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result and stalls on a pattern that steps through four modes as the cycle count advances.
	queue_reply_t want;
	int           results_seen = 0;
	int           rx_cycle = 0;
	int           rx_hold = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (out_valid && out_ready) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got status %0d value %0d",
						$time, status, item_value, " priority %0d count %0d",
						item_priority, entry_count);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.st || item_value !== want.val ||
							item_priority !== want.pri || entry_count !== want.cnt) begin
						errors++;
						$display("%0t: result mismatch, expected status %0d value %0d",
							$time, want.st, want.val, " priority %0d count %0d,",
							want.pri, want.cnt, " got status %0d value %0d priority %0d count %0d",
							status, item_value, item_priority, entry_count);
					end
				end
				// Long hold-offs while the sender keeps offering transactions.
				if (results_seen == 300 || results_seen == 650)
					rx_hold = 120;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				case ((rx_cycle / 64) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				2: out_ready <= (rx_cycle % 4 != 0);
				default: out_ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic add_cmd(input sspq_pkg::op_t op, input logic signed [sspq_pkg::VAL_W-1:0] v,
			input logic signed [sspq_pkg::PRI_W-1:0] p);
		queue_cmd_t c;
		c.op = op;
		c.val = v;
		c.pri = p;
		cmds_to_send.push_back(c);
		cmds_made++;
		if (op == sspq_pkg::OP_PUSH) begin
			recent_pushes.push_back(c);
			if (recent_pushes.size() > 24)
				void'(recent_pushes.pop_front());
		end
	endtask

	function automatic logic signed [sspq_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'sh7FFF_FFFF;
		1: return 32'sh8000_0000;
		2: return '0;
		3, 4, 5: return val_t'(int'($urandom_range(0, 40)) - 20);
		default: return val_t'($urandom());
		endcase
	endfunction

	function automatic logic signed [sspq_pkg::PRI_W-1:0] pick_pri(input int center, input bit wide);
		if (wide)
			return pri_t'($urandom());
		return pri_t'(center + int'($urandom_range(0, 2)) - 1);
	endfunction

	// Mostly aims near an entry pushed lately, often right at the tolerance edge.
	task automatic add_find(input int center, input bit wide);
		queue_cmd_t c;
		int d;
		if (recent_pushes.size() > 0 && $urandom_range(0, 4) != 0) begin
			c = recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
			if ($urandom_range(0, 3) == 0)
				d = int'(tolerance) - int'($urandom_range(0, 1));
			else
				d = $urandom_range(0, int'(tolerance) + 1);
			if ($urandom_range(0, 1))
				d = -d;
			add_cmd(sspq_pkg::OP_FIND, val_t'(c.val + d), c.pri);
		end else begin
			add_cmd(sspq_pkg::OP_FIND, pick_value(), pick_pri(center, wide));
		end
	endtask

	task automatic random_ops(input int n);
		int stop_at, kind, center, r;
		bit wide;
		stop_at = cmds_made + n;
		@(negedge clk);
		while (cmds_made < stop_at) begin
			kind = $urandom_range(0, 9);
			wide = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
			0: center = -127;
			1: center = 126;
			default: center = int'($urandom_range(0, 20)) - 10;
			endcase
			if (kind < 6) begin
				repeat ($urandom_range(4, 24)) begin
					r = $urandom_range(0, 99);
					if (r < 45)
						add_cmd(sspq_pkg::OP_PUSH, pick_value(), pick_pri(center, wide));
					else if (r < 75)
						add_cmd(sspq_pkg::OP_POP, $urandom(), pri_t'($urandom()));
					else if (r < 97)
						add_find(center, wide);
					else
						add_cmd(sspq_pkg::OP_UNUSED, $urandom(), pri_t'($urandom()));
				end
			end else if (kind < 9) begin
				// Fill towards and possibly past capacity, search, then drain towards and possibly past empty.
				repeat ($urandom_range(12, 19))
					add_cmd(sspq_pkg::OP_PUSH, pick_value(), pick_pri(center, wide));
				repeat ($urandom_range(3, 8))
					add_find(center, wide);
				repeat ($urandom_range(12, 20))
					add_cmd(sspq_pkg::OP_POP, $urandom(), pri_t'($urandom()));
			end else begin
				repeat ($urandom_range(4, 12))
					add_cmd(sspq_pkg::op_t'($urandom_range(0, 3)), $urandom(),
						pri_t'($urandom()));
			end
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (cmds_to_send.size() != 0 || in_valid || replies_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_tolerance(input logic [sspq_pkg::TOL_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		tolerance = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : main_seq
		logic [sspq_pkg::TOL_W-1:0] tol_plan[5];
		int len_plan[5];
		tol_plan = '{16'hFFFF, 16'd0, 16'd1, tol_t'($urandom_range(2, 4000)),
			sspq_pkg::TOL_RESET};
		len_plan = '{200, 110, 130, 230, 160};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset tolerance.
		add_cmd(sspq_pkg::OP_POP, 0, 0);
		add_cmd(sspq_pkg::OP_FIND, 0, 8'sd7);
		add_cmd(sspq_pkg::OP_UNUSED, 32'h1234_5678, -8'sd5);
		add_cmd(sspq_pkg::OP_PUSH, 32'h7FFF_FFFF, 8'sd127);
		add_cmd(sspq_pkg::OP_PUSH, 32'h8000_0000, -8'sd128);
		add_cmd(sspq_pkg::OP_PUSH, 0, 8'sd7);
		add_cmd(sspq_pkg::OP_PUSH, 5, 8'sd7);
		add_cmd(sspq_pkg::OP_PUSH, -3, 8'sd7);
		// All three equal-priority entries lie within reach; the oldest one must win.
		add_cmd(sspq_pkg::OP_FIND, 3, 8'sd7);
		add_cmd(sspq_pkg::OP_FIND, 12, 8'sd7);
		add_cmd(sspq_pkg::OP_FIND, 11, 8'sd7);
		add_cmd(sspq_pkg::OP_FIND, -9, 8'sd7);
		add_cmd(sspq_pkg::OP_FIND, 32'h7FFF_FFFF, 8'sd127);
		add_cmd(sspq_pkg::OP_FIND, 32'h7FFF_FFFF, -8'sd128);
		add_cmd(sspq_pkg::OP_FIND, 32'h8000_0004, -8'sd128);
		add_cmd(sspq_pkg::OP_UNUSED, -1, -8'sd1);
		repeat (6)
			add_cmd(sspq_pkg::OP_POP, 0, 0);

		for (int k = 0; k < 5; k++) begin
			drain();
			set_tolerance(tol_plan[k]);
			random_ops(len_plan[k]);
		end
		drain();
		repeat (25) @(posedge clk);

		$display("Covered %0d push (%0d dropped while full), %0d pop (%0d on empty),",
			op_seen[sspq_pkg::OP_PUSH], stat_seen[sspq_pkg::STAT_FULL],
			op_seen[sspq_pkg::OP_POP], stat_seen[sspq_pkg::STAT_EMPTY]);
		$display("%0d find (%0d without a match), %0d unused-code transactions, 6 tolerances.",
			op_seen[sspq_pkg::OP_FIND], stat_seen[sspq_pkg::STAT_MISS],
			op_seen[sspq_pkg::OP_UNUSED]);
		if (errors == 0)
			$display("stable_sorted_priority_queue_core regression: pass");
		else
			$display("stable_sorted_priority_queue_core regression: fail");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Timeout with %0d results still awaited.", replies_due.size());
		$display("stable_sorted_priority_queue_core regression: fail");
		$finish;
	end

endmodule
